/* design/lru_pkg.sv */
package lru_pkg;

    localparam int PAGES   = 32;
    localparam int FRAMES  = 16;
    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = 4;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = TIME_W + FRAME_W;

    localparam logic [CFG_W-1:0] FRAME_CNT_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] FRAMES_MAX      = CFG_W'(FRAMES);

    typedef struct packed {
        logic [TIME_W-1:0]  last_use;
        logic [FRAME_W-1:0] frame;
    } lru_entry_t;

    typedef struct packed {
        logic              clear;
        logic              step;
        logic [PAGE_W-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic               found;
        logic [PAGE_W-1:0]  victim;
        logic [FRAME_W-1:0] frame;
    } scan_res_t;

endpackage

/* design/lru_ram.sv */
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/lru_scan.sv */
module lru_scan (
    input  logic                aclk,
    input  lru_pkg::scan_ctrl_t ctrl,
    input  logic                entry_valid,
    input  lru_pkg::lru_entry_t entry,
    output lru_pkg::scan_res_t  res
);

    logic                        found_reg;
    logic [lru_pkg::TIME_W-1:0]  best_reg;
    logic [lru_pkg::PAGE_W-1:0]  victim_reg;
    logic [lru_pkg::FRAME_W-1:0] frame_reg;
    logic                        take;

    // A strict compare keeps the lowest-numbered page among equally old ones.
    assign take = ctrl.step && entry_valid && (!found_reg || (entry.last_use < best_reg));

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg  <= 1'b1;
            best_reg   <= entry.last_use;
            victim_reg <= ctrl.idx;
            frame_reg  <= entry.frame;
        end
    end

    assign res.found  = found_reg;
    assign res.victim = victim_reg;
    assign res.frame  = frame_reg;

endmodule

/* design/lru_page_replacement_top.sv */
// A hit or a fault that fills a free frame goes from ST_LOOK to ST_DONE, where its
// result is registered; a fault that evicts first runs ST_SCAN, a serial scan of the
// page table RAM, one entry a cycle, then ST_EVICT. ST_DONE waits for a free output.
// A new request is not taken while one is in work; the next request is accepted once
// the result has moved into the output register.
// Reset clears the valid bits, time stamp and fault count and restarts the fill state; frame count is 4.
module lru_page_replacement_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lru_pkg::PAGE_W-1:0]  s_page,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_fault,
    output logic [lru_pkg::FRAME_W-1:0] m_frame,
    output logic                        m_evicted_valid,
    output logic [lru_pkg::PAGE_W-1:0]  m_evicted_page,
    output logic [lru_pkg::CNT_W-1:0]   m_fault_total
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EVICT,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic [lru_pkg::PAGES-1:0]    page_valid_reg;
    logic [lru_pkg::CFG_W-1:0]    frame_count_reg;
    logic [lru_pkg::FRAME_W-1:0]  fill_ptr_reg;
    logic                         filling_reg;
    logic [lru_pkg::TIME_W-1:0]   time_reg;
    logic [lru_pkg::TIME_W-1:0]   now_reg;
    logic [lru_pkg::CNT_W-1:0]    fault_cnt_reg;
    logic [lru_pkg::PAGE_W-1:0]   page_reg;
    logic [lru_pkg::PAGE_W-1:0]   scan_reg;

    logic                         res_fault_reg;
    logic [lru_pkg::FRAME_W-1:0]  res_frame_reg;
    logic                         res_ev_valid_reg;
    logic [lru_pkg::PAGE_W-1:0]   res_ev_page_reg;

    logic                         m_valid_reg;
    logic                         m_fault_reg;
    logic [lru_pkg::FRAME_W-1:0]  m_frame_reg;
    logic                         m_ev_valid_reg;
    logic [lru_pkg::PAGE_W-1:0]   m_ev_page_reg;
    logic [lru_pkg::CNT_W-1:0]    m_total_reg;

    logic                         ram_we;
    logic [lru_pkg::PAGE_W-1:0]   ram_waddr;
    lru_pkg::lru_entry_t          ram_wentry;
    logic [lru_pkg::PAGE_W-1:0]   ram_raddr;
    logic [lru_pkg::ENTRY_W-1:0]  ram_rdata;
    lru_pkg::lru_entry_t          rd_entry;

    lru_pkg::scan_ctrl_t          scan_ctrl;
    lru_pkg::scan_res_t           scan_res;

    logic [lru_pkg::CFG_W-1:0]    limit;
    logic                         hit;
    logic                         fill_now;
    logic [lru_pkg::CFG_W-1:0]    fill_inc;
    logic [lru_pkg::FRAME_W-1:0]  evict_frame;
    logic                         out_free;
    logic [lru_pkg::PAGES-1:0]    evict_mask;
    logic [lru_pkg::PAGES-1:0]    page_mask;

    assign rd_entry = lru_pkg::lru_entry_t'(ram_rdata);
    assign hit      = page_valid_reg[page_reg];
    assign fill_inc = lru_pkg::CFG_W'(fill_ptr_reg) + lru_pkg::CFG_W'(1);
    assign fill_now = filling_reg && (lru_pkg::CFG_W'(fill_ptr_reg) < limit);
    assign evict_frame = scan_res.found ? scan_res.frame : '0;
    assign out_free = !m_valid_reg || m_ready;
    assign evict_mask = scan_res.found ? (lru_pkg::PAGES'(1) << scan_res.victim) : '0;
    assign page_mask  = lru_pkg::PAGES'(1) << page_reg;

    always_comb begin
        if (frame_count_reg == '0) begin
            limit = lru_pkg::CFG_W'(1);
        end else if (frame_count_reg > lru_pkg::FRAMES_MAX) begin
            limit = lru_pkg::FRAMES_MAX;
        end else begin
            limit = frame_count_reg;
        end
    end

    always_comb begin
        ram_we              = 1'b0;
        ram_waddr           = page_reg;
        ram_wentry.last_use = now_reg;
        ram_wentry.frame    = rd_entry.frame;
        ram_raddr           = '0;
        scan_ctrl.clear     = 1'b0;
        scan_ctrl.step      = 1'b0;
        scan_ctrl.idx       = scan_reg;
        case (state_reg)
            ST_IDLE: begin
                ram_raddr = s_page;
            end
            ST_LOOK: begin
                if (hit) begin
                    ram_we = 1'b1;
                end else if (fill_now) begin
                    ram_we           = 1'b1;
                    ram_wentry.frame = fill_ptr_reg;
                end else begin
                    scan_ctrl.clear = 1'b1;
                end
            end
            ST_SCAN: begin
                ram_raddr      = scan_reg + lru_pkg::PAGE_W'(1);
                scan_ctrl.step = 1'b1;
            end
            ST_EVICT: begin
                ram_we           = 1'b1;
                ram_wentry.frame = evict_frame;
            end
            default: begin
            end
        endcase
    end

    lru_ram #(
        .WIDTH(lru_pkg::ENTRY_W),
        .DEPTH(lru_pkg::PAGES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lru_scan u_scan (
        .aclk        (aclk),
        .ctrl        (scan_ctrl),
        .entry_valid (page_valid_reg[scan_reg]),
        .entry       (rd_entry),
        .res         (scan_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            page_valid_reg  <= '0;
            frame_count_reg <= lru_pkg::FRAME_CNT_RESET;
            fill_ptr_reg    <= '0;
            filling_reg     <= 1'b1;
            time_reg        <= '0;
            fault_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                frame_count_reg <= cfg_wdata;
            end
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        page_reg  <= s_page;
                        now_reg   <= time_reg;
                        time_reg  <= time_reg + lru_pkg::TIME_W'(1);
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    res_ev_valid_reg <= 1'b0;
                    res_ev_page_reg  <= '0;
                    if (hit) begin
                        res_fault_reg <= 1'b0;
                        res_frame_reg <= rd_entry.frame;
                        state_reg     <= ST_DONE;
                    end else begin
                        res_fault_reg <= 1'b1;
                        if (fault_cnt_reg != '1) begin
                            fault_cnt_reg <= fault_cnt_reg + lru_pkg::CNT_W'(1);
                        end
                        if (fill_now) begin
                            res_frame_reg            <= fill_ptr_reg;
                            page_valid_reg[page_reg] <= 1'b1;
                            if (fill_inc >= limit) begin
                                fill_ptr_reg <= '0;
                                filling_reg  <= 1'b0;
                            end else begin
                                fill_ptr_reg <= fill_inc[lru_pkg::FRAME_W-1:0];
                            end
                            state_reg <= ST_DONE;
                        end else begin
                            filling_reg <= 1'b0;
                            scan_reg    <= '0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_reg <= scan_reg + lru_pkg::PAGE_W'(1);
                    if (scan_reg == lru_pkg::PAGE_W'(lru_pkg::PAGES - 1)) begin
                        state_reg <= ST_EVICT;
                    end
                end
                ST_EVICT: begin
                    res_frame_reg <= evict_frame;
                    if (scan_res.found) begin
                        res_ev_valid_reg <= 1'b1;
                        res_ev_page_reg  <= scan_res.victim;
                    end
                    page_valid_reg <= (page_valid_reg & ~evict_mask) | page_mask;
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_fault_reg    <= res_fault_reg;
                        m_frame_reg    <= res_frame_reg;
                        m_ev_valid_reg <= res_ev_valid_reg;
                        m_ev_page_reg  <= res_ev_page_reg;
                        m_total_reg    <= fault_cnt_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_fault         = m_fault_reg;
    assign m_frame         = m_frame_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_total   = m_total_reg;

    // A request leaves the block busy for at least the table lookup.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a previous one is in work");

    // Only a fault can evict a page.
    a_evict_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> m_fault)
        else $error("eviction reported on a hit");

    // The fault count never moves backward.
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> fault_cnt_reg >= $past(fault_cnt_reg))
        else $error("fault count decreased");

    // The referenced page is resident whenever its result is issued.
    a_page_resident: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> page_valid_reg[page_reg])
        else $error("referenced page not marked valid");

endmodule
